// ===== design/mss_pkg.sv =====
// ----------------------------------------------------------------------------
// mss_pkg
// Shared types, mood tables, pitch, gain and sine tables for the music
// sequencer synthesizer.
// ----------------------------------------------------------------------------
package mss_pkg;

  localparam int VOICE_COUNT      = 4;
  localparam int SAMPLE_RATE      = 22050;
  localparam int SINE_TABLE_DEPTH = 256;
  localparam int SINE_BITS        = $clog2(SINE_TABLE_DEPTH);
  localparam int NUM_MOODS        = 11;
  localparam int INC_DEPTH        = 66;
  localparam int INC_BITS         = $clog2(INC_DEPTH);
  localparam int STAGE_COUNT      = 7;
  localparam int DECAY_DEN        = 10 * SAMPLE_RATE;

  localparam logic [23:0] ONE_Q23   = 24'd8388608;
  localparam logic [23:0] QUIET_AMP = 24'd4194;
  localparam logic [23:0] DUCK_LOW  = 24'd3187671;
  localparam logic [31:0] DUCK_RATE = 32'd1073742;
  localparam logic [31:0] OUT_TRIM  = 32'd7130317;
  localparam logic [31:0] RECIP10   = 32'hCCCCCCCD;
  localparam logic [31:0] OUT_SCALE = 32'd26000;
  localparam logic [31:0] PAD_MIX1  = 32'd5872026;
  localparam logic [31:0] BELL_MIX1 = 32'd4194304;
  localparam logic [31:0] HARM_MIX  = 32'd1677722;

  localparam logic [0:0] CFG_BRIGHTNESS = 1'b0;
  localparam logic [0:0] CFG_VOLUME     = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE, S_MOOD, S_SEQ, S_PH, S_W1, S_W2, S_W3, S_A, S_G, S_D, S_DE,
    S_DK1, S_DK2, S_O1, S_O2, S_O3, S_O4, S_O5, S_O6
  } state_t;

  typedef logic signed [24:0] sine_tab_t [SINE_TABLE_DEPTH];
  typedef logic [23:0] inc_tab_t [INC_DEPTH];
  typedef logic [12:0] tempo_tab_t [NUM_MOODS];
  typedef logic [23:0] mood_gain_t [NUM_MOODS];
  typedef logic [23:0] stage_gain_t [STAGE_COUNT];
  typedef logic [23:0] decay_tab_t [VOICE_COUNT];

  localparam logic signed [7:0] MOOD_ROOT [NUM_MOODS] =
    '{0, 0, -2, 5, -4, 2, -5, 3, -1, -7, 0};
  localparam int MOOD_BPM [NUM_MOODS] =
    '{60, 76, 68, 92, 64, 72, 60, 84, 70, 54, 100};
  localparam int MOOD_WARMTH [NUM_MOODS] =
    '{0, 55, 35, 70, 45, 62, 30, 50, 40, 25, 95};
  localparam logic signed [7:0] MOOD_SCALE [NUM_MOODS][7] = '{
    '{0,0,0,0,0,0,0},   '{0,2,4,5,7,9,11}, '{0,2,3,5,7,8,10},
    '{0,2,4,5,7,9,11},  '{0,2,3,5,7,8,10}, '{0,2,4,7,9,11,12},
    '{0,2,3,5,7,8,10},  '{0,2,4,5,7,9,11}, '{0,2,3,5,7,9,10},
    '{0,2,3,5,7,8,10},  '{0,2,4,5,7,9,11}};
  localparam logic [2:0] MOOD_PATTERN [NUM_MOODS][8] = '{
    '{0,0,0,0,0,0,0,0}, '{0,4,2,4,5,4,2,0}, '{0,2,4,2,6,4,2,0},
    '{0,2,4,5,4,2,0,4}, '{0,3,2,0,0,3,5,3}, '{0,2,4,6,4,2,0,0},
    '{0,0,4,3,2,0,5,4}, '{0,4,2,5,4,2,6,4}, '{0,2,0,4,2,0,5,2},
    '{0,0,0,3,0,0,2,0}, '{0,4,7,4,5,7,4,2}};
  localparam logic [7:0] MOOD_REST [NUM_MOODS] =
    '{8'hFF, 8'h00, 8'h80, 8'h00, 8'h10, 8'h40, 8'h22, 8'h00, 8'h24, 8'hB6, 8'h00};

  localparam logic [2:0] BAR_DEGREE [4] = '{3'd0, 3'd5, 3'd3, 3'd4};
  localparam logic [2:0] PAD_DEG    [4] = '{3'd2, 3'd0, 3'd5, 3'd6};
  localparam logic [2:0] BELL_DEG   [4] = '{3'd4, 3'd2, 3'd0, 3'd1};

  localparam logic [63:0] SEMI_HZ [12] = '{
    64'd8572764, 64'd9082527, 64'd9622602, 64'd10194792, 64'd10801006,
    64'd11443267, 64'd12123719, 64'd12844633, 64'd13608415, 64'd14417613,
    64'd15274929, 64'd16183224};

  localparam int DECAY_TENTHS [VOICE_COUNT] = '{16, 9, 32, 40};

  function automatic sine_tab_t build_sine();
    sine_tab_t t;
    logic [63:0] p, q, r, x, x2, s, y, v;
    for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
      p = (64'(i) << 24) / SINE_TABLE_DEPTH;
      q = (p >> 22) & 64'd3;
      r = p & 64'h3FFFFF;
      if (q[0]) r = 64'h400000 - r;
      x = r << 8;
      x2 = (x * x) >> 30;
      s = 64'd172273;
      s = 64'd5026995 - ((x2 * s) >> 30);
      s = 64'd85569306 - ((x2 * s) >> 30);
      s = 64'd693598668 - ((x2 * s) >> 30);
      s = 64'd1686629713 - ((x2 * s) >> 30);
      y = (x * s) >> 30;
      v = (y + 64'd64) >> 7;
      if (v > 64'(ONE_Q23)) v = 64'(ONE_Q23);
      t[i] = (q >= 64'd2) ? -$signed(25'(v)) : $signed(25'(v));
    end
    return t;
  endfunction

  function automatic inc_tab_t build_inc();
    inc_tab_t t;
    int oct, n;
    for (int i = 0; i < INC_DEPTH; i++) begin
      oct = i / 12;
      n = i % 12;
      t[i] = 24'((SEMI_HZ[n] << (6 + oct)) / SAMPLE_RATE);
    end
    return t;
  endfunction

  function automatic tempo_tab_t build_tempo();
    tempo_tab_t t;
    for (int m = 0; m < NUM_MOODS; m++) begin
      t[m] = 13'((15 * SAMPLE_RATE) / MOOD_BPM[m]);
    end
    return t;
  endfunction

  function automatic mood_gain_t build_bass_gain();
    mood_gain_t t;
    for (int m = 0; m < NUM_MOODS; m++) begin
      t[m] = 24'(((64'(3000 + 6 * MOOD_WARMTH[m]) << 23) + 64'd5000) / 10000);
    end
    return t;
  endfunction

  function automatic stage_gain_t build_pad_gain();
    stage_gain_t t;
    for (int s = 0; s < STAGE_COUNT; s++) begin
      t[s] = 24'(((64'(90 + 5 * s) << 23) + 64'd300) / 600);
    end
    return t;
  endfunction

  function automatic stage_gain_t build_lead_gain();
    stage_gain_t t;
    for (int s = 0; s < STAGE_COUNT; s++) begin
      t[s] = 24'(((64'(66 + 3 * s) << 23) + 64'd300) / 600);
    end
    return t;
  endfunction

  function automatic decay_tab_t build_decay();
    decay_tab_t t;
    for (int v = 0; v < VOICE_COUNT; v++) begin
      t[v] = 24'(((64'(DECAY_TENTHS[v]) << 23) + 64'(DECAY_DEN / 2)) / DECAY_DEN);
    end
    return t;
  endfunction

  localparam sine_tab_t   SINE_TAB  = build_sine();
  localparam inc_tab_t    INC_TAB   = build_inc();
  localparam tempo_tab_t  TEMPO_TAB = build_tempo();
  localparam mood_gain_t  BASS_GAIN = build_bass_gain();
  localparam stage_gain_t PAD_GAIN  = build_pad_gain();
  localparam stage_gain_t LEAD_GAIN = build_lead_gain();
  localparam decay_tab_t  DECAY_TAB = build_decay();
  localparam logic [23:0] BELL_GAIN = 24'(((64'd7 << 23) + 64'd50) / 100);

endpackage

// ===== design/music_sequencer_synth_top.sv =====
// ----------------------------------------------------------------------------
// music_sequencer_synth_top
// Four-voice mood sequencer and synthesizer: one clipped sample per tick word,
// all multiplications through one shared registered 32x32 multiplier.
// ----------------------------------------------------------------------------
// Sequence: after input accept, mood and sequencer setup states; per voice,
//   a phase state when quiet, or phase, wave, amplitude, gain and decay states
//   when sounding; then duck and output states. One word at a time, accepted
//   only in idle. The output register frees the input side.
// Reset: synchronous, active high; clears voices, sequencer, moods and config
//   (volume 10, brightness 0); no clearing pass.
module music_sequencer_synth_top
  import mss_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [3:0] new_mood, [4] duck
  input  logic        s_tuser,   // [0] set_mood
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [15:0] sample, [19:16] current_mood
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_data
);

  state_t state, state_next;

  logic [2:0]  brightness_stage;
  logic [3:0]  master_volume;
  logic [23:0] voice_phase     [VOICE_COUNT];
  logic [23:0] voice_increment [VOICE_COUNT];
  logic [23:0] voice_amplitude [VOICE_COUNT];
  logic [23:0] voice_gain      [VOICE_COUNT];
  logic [23:0] duck_gain;
  logic [5:0]  step_count;
  logic [12:0] step_length;
  logic [12:0] step_remaining;
  logic [3:0]  playing_mood;
  logic [3:0]  pending_mood;

  logic        in_set;
  logic [3:0]  in_mood;
  logic        duck_on;
  logic [1:0]  vi;
  logic [23:0] cur_p;
  logic signed [25:0] wreg;
  logic signed [25:0] treg;
  logic        sgn1, sgn2, wneg, oneg;
  logic signed [31:0] mix;
  logic [63:0] prod;
  logic [31:0] mul_a, mul_b;
  logic [15:0] sample_q;
  logic [3:0]  mood_q;

  // sequencer step
  logic [2:0]  stage;
  logic [2:0]  deg, lead_deg;
  logic [2:0]  slot;
  logic signed [7:0] root;
  logic signed [7:0] bass_s, pad_s, lead_s, bell_s;
  logic [5:0]  sc_inc;
  logic        seq_swap;
  logic [12:0] seq_len;

  // voice datapath
  logic signed [24:0] sine_p, sine_k;
  logic [23:0] kp;
  logic [24:0] sine_p_mag, sine_k_mag;
  logic [25:0] w_mag;
  logic [32:0] dec;
  logic signed [24:0] diff;
  logic [24:0] diff_mag;
  logic [23:0] duck_step;
  logic [31:0] mix_mag;
  logic [28:0] quot;
  logic [23:0] clip;
  logic        quiet;
  logic [15:0] mag;

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign m_tdata   = {4'd0, mood_q, sample_q};

  assign stage    = (brightness_stage > 3'd6) ? 3'd6 : brightness_stage;
  assign root     = MOOD_ROOT[playing_mood];
  assign deg      = BAR_DEGREE[step_count[5:4]];
  assign slot     = step_count[3:1];
  assign lead_deg = (MOOD_PATTERN[playing_mood][slot] == 3'd7) ? 3'd0
                                                               : MOOD_PATTERN[playing_mood][slot];
  assign bass_s = root + MOOD_SCALE[playing_mood][deg] + 8'sd12;
  assign pad_s  = root + MOOD_SCALE[playing_mood][PAD_DEG[step_count[5:4]]] + 8'sd24;
  assign lead_s = root + MOOD_SCALE[playing_mood][lead_deg] + 8'sd36;
  assign bell_s = root + MOOD_SCALE[playing_mood][BELL_DEG[step_count[5:4]]] + 8'sd48;
  assign sc_inc   = step_count + 6'd1;
  assign seq_swap = (sc_inc[3:0] == 4'd0) && (pending_mood != playing_mood);
  assign seq_len  = seq_swap ? TEMPO_TAB[pending_mood] : step_length;

  assign quiet      = voice_amplitude[vi] <= QUIET_AMP;
  assign kp         = (vi == 2'd1) ? {cur_p[22:0], 1'b0} : cur_p + {cur_p[22:0], 1'b0};
  assign sine_p     = SINE_TAB[cur_p[23 -: SINE_BITS]];
  assign sine_k     = SINE_TAB[kp[23 -: SINE_BITS]];
  assign sine_p_mag = sine_p[24] ? 25'(-sine_p) : 25'(sine_p);
  assign sine_k_mag = sine_k[24] ? 25'(-sine_k) : 25'(sine_k);
  assign w_mag      = wreg[25] ? 26'(-wreg) : 26'(wreg);
  assign dec        = (prod[55:23] == 33'd0) ? 33'd1 : prod[55:23];
  assign diff       = $signed({1'b0, duck_on ? DUCK_LOW : ONE_Q23})
                    - $signed({1'b0, duck_gain});
  assign diff_mag   = diff[24] ? 25'(-diff) : 25'(diff);
  assign duck_step  = prod[55:32];
  assign mix_mag    = mix[31] ? 32'(-mix) : 32'(mix);
  assign quot       = prod[63:35];
  assign clip       = (quot > 29'(ONE_Q23)) ? ONE_Q23 : quot[23:0];
  assign mag        = prod[38:23];

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (s_tvalid) state_next = S_MOOD;
      S_MOOD: state_next = S_SEQ;
      S_SEQ:  state_next = S_PH;
      S_PH: begin
        if (!quiet)            state_next = S_W1;
        else if (vi == 2'd3)   state_next = S_DK1;
        else                   state_next = S_PH;
      end
      S_W1:   state_next = (vi[0]) ? S_W2 : S_A;
      S_W2:   state_next = S_W3;
      S_W3:   state_next = S_A;
      S_A:    state_next = S_G;
      S_G:    state_next = S_D;
      S_D:    state_next = S_DE;
      S_DE:   state_next = (vi == 2'd3) ? S_DK1 : S_PH;
      S_DK1:  state_next = S_DK2;
      S_DK2:  state_next = S_O1;
      S_O1:   state_next = S_O2;
      S_O2:   state_next = S_O3;
      S_O3:   state_next = S_O4;
      S_O4:   state_next = S_O5;
      S_O5:   state_next = S_O6;
      S_O6:   if (!m_tvalid || m_tready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    case (state)
      S_W1: begin
        mul_a = 32'(sine_p_mag);
        mul_b = (vi == 2'd1) ? PAD_MIX1 : BELL_MIX1;
      end
      S_W2: begin
        mul_a = 32'(sine_k_mag);
        mul_b = HARM_MIX;
      end
      S_A: begin
        mul_a = 32'(w_mag);
        mul_b = 32'(voice_amplitude[vi]);
      end
      S_G: begin
        mul_a = prod[54:23];
        mul_b = 32'(voice_gain[vi]);
      end
      S_D: begin
        mul_a = 32'(voice_amplitude[vi]);
        mul_b = 32'(DECAY_TAB[vi]);
      end
      S_DK1: begin
        mul_a = 32'(diff_mag);
        mul_b = DUCK_RATE;
      end
      S_O1: begin
        mul_a = mix_mag;
        mul_b = 32'(duck_gain);
      end
      S_O2: begin
        mul_a = prod[54:23];
        mul_b = OUT_TRIM;
      end
      S_O3: begin
        mul_a = prod[54:23];
        mul_b = 32'(master_volume);
      end
      S_O4: begin
        mul_a = prod[31:0];
        mul_b = RECIP10;
      end
      S_O5: begin
        mul_a = 32'(clip);
        mul_b = OUT_SCALE;
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state != S_O6) prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      brightness_stage <= 3'd0;
      master_volume    <= 4'd10;
      for (int v = 0; v < VOICE_COUNT; v++) begin
        voice_phase[v]     <= 24'd0;
        voice_increment[v] <= 24'd0;
        voice_amplitude[v] <= 24'd0;
        voice_gain[v]      <= 24'd0;
      end
      duck_gain      <= ONE_Q23;
      step_count     <= 6'd0;
      step_length    <= 13'd4351;
      step_remaining <= 13'd0;
      playing_mood   <= 4'd0;
      pending_mood   <= 4'd0;
      duck_on        <= 1'b0;
      vi             <= 2'd0;
      m_tvalid       <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_index[1] == 1'b0) begin
        if (cfg_index[0] == CFG_BRIGHTNESS) brightness_stage <= cfg_data[2:0];
        else                                master_volume    <= cfg_data;
      end
      if (state == S_O6 && (!m_tvalid || m_tready)) m_tvalid <= 1'b1;
      else if (m_tvalid && m_tready)                m_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            in_set  <= s_tuser;
            in_mood <= s_tdata[3:0];
            duck_on <= s_tdata[4];
          end
        end
        S_MOOD: begin
          if (in_set && in_mood < 4'(NUM_MOODS)) begin
            pending_mood <= in_mood;
            if (playing_mood == 4'd0) begin
              playing_mood <= in_mood;
              step_count   <= 6'd0;
              step_length  <= TEMPO_TAB[in_mood];
            end
          end
        end
        S_SEQ: begin
          vi  <= 2'd0;
          mix <= 32'sd0;
          if (step_remaining == 13'd0) begin
            if (playing_mood != 4'd0) begin
              if (step_count[2:0] == 3'd0) begin
                voice_increment[0] <= INC_TAB[bass_s[INC_BITS-1:0]];
                voice_amplitude[0] <= ONE_Q23;
                voice_gain[0]      <= BASS_GAIN[playing_mood];
              end
              if (step_count[2:0] == 3'd0 && stage >= 3'd1) begin
                voice_increment[1] <= INC_TAB[pad_s[INC_BITS-1:0]];
                voice_amplitude[1] <= ONE_Q23;
                voice_gain[1]      <= PAD_GAIN[stage];
              end
              if (stage >= 3'd2 && !step_count[0] && !MOOD_REST[playing_mood][slot]) begin
                voice_increment[2] <= INC_TAB[lead_s[INC_BITS-1:0]];
                voice_amplitude[2] <= ONE_Q23;
                voice_gain[2]      <= LEAD_GAIN[stage];
              end
              if (stage >= 3'd4 && step_count[3:0] == 4'd12) begin
                voice_increment[3] <= INC_TAB[bell_s[INC_BITS-1:0]];
                voice_amplitude[3] <= ONE_Q23;
                voice_gain[3]      <= BELL_GAIN;
              end
              if (seq_swap) begin
                playing_mood <= pending_mood;
                step_length  <= seq_len;
                step_count   <= 6'd0;
              end else begin
                step_count <= sc_inc;
              end
              step_remaining <= seq_len - 13'd1;
            end else begin
              step_remaining <= step_length - 13'd1;
            end
          end else begin
            step_remaining <= step_remaining - 13'd1;
          end
        end
        S_PH: begin
          if (!quiet) begin
            voice_phase[vi] <= voice_phase[vi] + voice_increment[vi];
            cur_p           <= voice_phase[vi] + voice_increment[vi];
          end else begin
            vi <= vi + 2'd1;
          end
        end
        S_W1: begin
          sgn1 <= sine_p[24];
          if (vi == 2'd0) begin
            wreg <= cur_p[23] ? $signed(26'd25165824) - $signed({1'b0, cur_p, 1'b0})
                              : $signed({1'b0, cur_p, 1'b0}) - $signed(26'(ONE_Q23));
          end else if (vi == 2'd2) begin
            wreg <= 26'(sine_p);
          end
        end
        S_W2: begin
          treg <= sgn1 ? -$signed(prod[48:23]) : $signed(prod[48:23]);
          sgn2 <= sine_k[24];
        end
        S_W3: begin
          wreg <= treg + (sgn2 ? -$signed(prod[48:23]) : $signed(prod[48:23]));
        end
        S_A: wneg <= wreg[25];
        S_D: mix <= mix + (wneg ? -$signed(prod[54:23]) : $signed(prod[54:23]));
        S_DE: begin
          voice_amplitude[vi] <= (33'(voice_amplitude[vi]) > dec)
                               ? voice_amplitude[vi] - dec[23:0] : 24'd0;
          vi <= vi + 2'd1;
        end
        S_DK2: duck_gain <= diff[24] ? duck_gain - duck_step : duck_gain + duck_step;
        S_O1:  oneg <= mix[31];
        S_O6: begin
          if (!m_tvalid || m_tready) begin
            sample_q <= oneg ? 16'(-mag) : mag;
            mood_q   <= playing_mood;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== design/mss_checker.sv =====
// ----------------------------------------------------------------------------
// mss_checker
// Port-level checks for the music sequencer synthesizer, bound to the top.
// ----------------------------------------------------------------------------
module mss_checker
  import mss_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while a word is in progress");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled output word changed");

  a_sample_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[15:0]) >= -16'sd26000) &&
                 ($signed(m_tdata[15:0]) <= 16'sd26000))
    else $error("sample out of range");

  a_mood_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[19:16] < 4'(NUM_MOODS))
    else $error("mood out of range");

endmodule

bind music_sequencer_synth_top mss_checker u_mss_checker (.*);
